FILE: sv/rcfp_pkg.sv
package rcfp_pkg;

    // frame layout
    localparam int          MaxFrameBytesDef = 24;
    localparam int          PayloadBytes     = 12;
    localparam int          QueueDepth       = 2;
    localparam int          OffsetW          = 15;
    localparam int          JoyAxes          = 6;

    localparam logic [7:0]  SyncByte1   = 8'hA5;
    localparam logic [7:0]  SyncByte2   = 8'h5A;
    localparam logic [7:0]  TrailerByte = 8'hAA;
    localparam logic [8:0]  MinLen      = 9'd3;

    // command codes
    localparam logic [7:0]  CmdJoy    = 8'hF5;
    localparam logic [7:0]  CmdServo3 = 8'hF1;
    localparam logic [7:0]  CmdServo4 = 8'hF2;
    localparam logic [7:0]  CmdServo5 = 8'hF3;
    localparam logic [7:0]  CmdModeA  = 8'hB1;
    localparam logic [7:0]  CmdModeB  = 8'hB2;
    localparam logic [7:0]  CmdModeC  = 8'hB3;
    localparam logic [7:0]  CmdModeF  = 8'hB4;
    localparam logic [7:0]  CmdKey    = 8'hB5;
    localparam logic [7:0]  CmdModeR  = 8'hB7;
    localparam logic [7:0]  CmdModeL  = 8'hB9;

    // mode letters
    localparam logic [15:0] LetterA = 16'h0041;
    localparam logic [15:0] LetterB = 16'h0042;
    localparam logic [15:0] LetterC = 16'h0043;
    localparam logic [15:0] LetterF = 16'h0046;
    localparam logic [15:0] LetterR = 16'h0052;
    localparam logic [15:0] LetterL = 16'h004C;

    localparam logic [15:0] ServoMax = 16'h7FFF;

    // event kinds
    localparam logic [1:0]  KindJoy   = 2'd0;
    localparam logic [1:0]  KindServo = 2'd1;
    localparam logic [1:0]  KindMode  = 2'd2;
    localparam logic [1:0]  KindKey   = 2'd3;

    localparam logic [2:0]  ChanServo3 = 3'd3;
    localparam logic [2:0]  ChanServo4 = 3'd4;
    localparam logic [2:0]  ChanServo5 = 3'd5;
    localparam logic [2:0]  ChanNone   = 3'd0;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_SYNC2 = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_CMD   = 5'b01000,
        PH_BODY  = 5'b10000
    } phase_t;

    // one decoded frame, waiting to be expanded into results
    typedef struct packed {
        logic                              joy;
        logic [1:0]                        kind;
        logic [2:0]                        chan;
        logic [15:0]                       val;
        logic [PayloadBytes-1:0][7:0]      payload;
    } job_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

FILE: sv/rcfp_front.sv
module rcfp_front
    import rcfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic [OffsetW-1:0] servo_offset,
    input  q_stat_t            q_stat,
    output logic               push,
    output job_t               job
);

    localparam int         PosW   = $clog2(MAX_FRAME_BYTES);
    localparam logic [8:0] MaxLen = 9'(MAX_FRAME_BYTES - 2);

    phase_t                        phase_reg, phase_next;
    logic [PosW-1:0]               left_reg, left_next;
    logic [PosW-1:0]               pos_reg, pos_next;
    logic [7:0]                    cmd_reg, cmd_next;
    logic [PayloadBytes-1:0][7:0]  payload_reg, payload_next;
    logic                          key_reg, key_next;

    logic        accept;
    logic [15:0] servo_sum;
    logic [15:0] servo_val;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    assign servo_sum = {1'b0, servo_offset} + {8'd0, payload_reg[0]};
    assign servo_val = servo_sum[15] ? ServoMax : servo_sum;

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        cmd_next     = cmd_reg;
        payload_next = payload_reg;
        key_next     = key_reg;
        push         = 1'b0;
        job          = '0;
        job.payload  = payload_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SyncByte1)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    priority if (rx_byte == SyncByte2)
                        phase_next = PH_LEN;
                    else if (rx_byte == SyncByte1)
                        phase_next = PH_SYNC2;
                    else
                        phase_next = PH_HUNT;
                end
                PH_LEN:
                begin
                    left_next = PosW'(rx_byte - 8'd2);
                    if ({1'b0, rx_byte} < MinLen || {1'b0, rx_byte} > MaxLen)
                        phase_next = PH_HUNT;
                    else
                        phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next     = rx_byte;
                    payload_next = '0;
                    pos_next     = '0;
                    phase_next   = PH_BODY;
                end
                PH_BODY:
                begin
                    if (left_reg <= PosW'(1))
                    begin
                        left_next  = '0;
                        phase_next = PH_HUNT;
                        if (rx_byte == TrailerByte)
                        begin
                            push = 1'b1;
                            unique case (cmd_reg)
                                CmdJoy:    job.joy = 1'b1;
                                CmdServo3: begin job.kind = KindServo; job.chan = ChanServo3;
                                                 job.val = servo_val; end
                                CmdServo4: begin job.kind = KindServo; job.chan = ChanServo4;
                                                 job.val = servo_val; end
                                CmdServo5: begin job.kind = KindServo; job.chan = ChanServo5;
                                                 job.val = servo_val; end
                                CmdModeA:  begin job.kind = KindMode; job.val = LetterA; end
                                CmdModeB:  begin job.kind = KindMode; job.val = LetterB; end
                                CmdModeC:  begin job.kind = KindMode; job.val = LetterC; end
                                CmdModeF:  begin job.kind = KindMode; job.val = LetterF; end
                                CmdModeR:  begin job.kind = KindMode; job.val = LetterR; end
                                CmdModeL:  begin job.kind = KindMode; job.val = LetterL; end
                                CmdKey:
                                begin
                                    key_next = ~key_reg;
                                    job.kind = KindKey;
                                    job.val  = {15'd0, ~key_reg};
                                end
                                default:   push = 1'b0;
                            endcase
                        end
                    end
                    else
                    begin
                        // bytes past the store are counted only
                        for (int i = 0; i < PayloadBytes; i++)
                        begin
                            if (pos_reg == PosW'(i))
                                payload_next[i] = rx_byte;
                        end
                        pos_next  = pos_reg + PosW'(1);
                        left_next = left_reg - PosW'(1);
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            left_reg    <= '0;
            pos_reg     <= '0;
            cmd_reg     <= '0;
            payload_reg <= '0;
            key_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
            cmd_reg     <= cmd_next;
            payload_reg <= payload_next;
            key_reg     <= key_next;
        end
    end

endmodule

FILE: sv/rcfp_queue.sv
module rcfp_queue
    import rcfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t q_stat
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    job_t            slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CntW'(QueueDepth));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/rcfp_back.sv
module rcfp_back
    import rcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head_job,
    input  q_stat_t     q_stat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [2:0]  channel,
    output logic signed [15:0] value,
    output logic        last
);

    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [2:0]        chan_reg, chan_next;
    logic [15:0]       val_reg, val_next;
    logic              last_reg, last_next;
    logic [2:0]        axis_reg, axis_next;
    logic              load;
    logic [15:0]       axis_val;

    assign load = !valid_reg || !out_stall;

    // big-endian pair for the current axis
    always_comb
    begin
        axis_val = '0;
        for (int i = 0; i < JoyAxes; i++)
        begin
            if (axis_reg == 3'(i))
                axis_val = {head_job.payload[2 * i], head_job.payload[2 * i + 1]};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        chan_next  = chan_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        axis_next  = axis_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !q_stat.empty;
            if (!q_stat.empty)
            begin
                if (head_job.joy)
                begin
                    kind_next = KindJoy;
                    chan_next = axis_reg;
                    val_next  = axis_val;
                    last_next = (axis_reg == 3'(JoyAxes - 1));
                    if (axis_reg == 3'(JoyAxes - 1))
                    begin
                        pop       = 1'b1;
                        axis_next = '0;
                    end
                    else
                        axis_next = axis_reg + 3'd1;
                end
                else
                begin
                    kind_next = head_job.kind;
                    chan_next = head_job.chan;
                    val_next  = head_job.val;
                    last_next = 1'b1;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            axis_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        chan_reg <= chan_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    assign out_valid  = valid_reg;
    assign event_kind = kind_reg;
    assign channel    = chan_reg;
    assign value      = signed'(val_reg);
    assign last       = last_reg;

endmodule

FILE: sv/remote_command_frame_parser_top.sv
// a frame enters the queue when its trailer byte is taken; its results then load the output register
// throughput: one received byte per cycle while in_stall is low and one result per cycle while
//   out_stall is low; a joystick frame drains as six results from the output register
// input stalls only while the two-entry frame queue between parser and emitter is full
// reset (rst_n, async, active low): hunt for the first header byte, key flag off,
//   payload store zero, queue empty, servo offset 200
module remote_command_frame_parser_top
    import rcfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MaxFrameBytesDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    // received bytes
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    // servo offset register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [OffsetW-1:0] cfg_data,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_kind,
    output logic [2:0]         channel,
    output logic signed [15:0] value,
    output logic               last
);

    logic [OffsetW-1:0] servo_offset_reg, servo_offset_next;

    logic    q_push;
    logic    q_pop;
    job_t    push_job;
    job_t    head_job;
    q_stat_t q_stat;

    // the user must change config only while idle; the block does not enforce it and the register is always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        servo_offset_next = servo_offset_reg;
        if (cfg_valid && cfg_ready)
            servo_offset_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            servo_offset_reg <= OffsetW'(200);
        else
            servo_offset_reg <= servo_offset_next;
    end

    // front: byte hunt, length check, payload capture, command decode, key flag
    rcfp_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .servo_offset (servo_offset_reg),
        .q_stat       (q_stat),
        .push         (q_push),
        .job          (push_job)
    );

    // short queue of decoded frames, each carrying its payload snapshot
    rcfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // back: expands a frame into results through the output register
    rcfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .channel    (channel),
        .value      (value),
        .last       (last)
    );

    // the parser never pushes a frame into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("frame pushed into full queue");

    // the emitter never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("frame popped from empty queue");

    // servo results carry a servo channel, a non-negative target and end the frame
    a_servo_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KindServo) |->
            (channel >= ChanServo3 && channel <= ChanServo5 && !value[15] && last))
        else $error("malformed servo result");

    // key results report a single bit
    a_key_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KindKey) |-> (value == 16'sd0 || value == 16'sd1))
        else $error("key result is not a bit");

endmodule

FILE: tb/sv/remote_command_frame_parser_top_tb.sv
`timescale 1ns / 100ps

module remote_command_frame_parser_top_tb;
    import rcfp_pkg::*;

    // how a directed row is judged
    typedef enum logic [1:0] {
        CHECK_MODEL,    // results come from the frame predictor
        CHECK_NONE,     // the frame must give no result at all
        CHECK_ONE       // exactly the one result typed into the row
    } row_check_t;

    // one result item as it leaves the block
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  chan;
        logic [15:0] val;
        logic        last;
    } rc_event_t;

    // one frame of stimulus, optionally preceded by one or two loose bytes
    typedef struct packed {
        row_check_t  check;
        logic [1:0]  nlead;
        logic [15:0] lead;      // loose bytes, high byte goes out first
        logic [7:0]  len;
        logic [7:0]  cmd;
        logic [7:0]  data0;     // first data byte
        logic [7:0]  fill;      // every further data byte
        logic [7:0]  trailer;
        logic        rnd_body;  // data bytes drawn at random instead
        rc_event_t   want;
    } frame_row_t;

    localparam int         SettleCycles  = 8;
    localparam int         WatchdogLimit = 2000;
    localparam int         PhaseBytes    = 30;
    localparam int         IdlePct       = 31;
    localparam rc_event_t  NoEvent       = '0;
    localparam logic [7:0] MaxLen        = 8'(MaxFrameBytesDef - 2);

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte   = 8'd0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [OffsetW-1:0] cfg_data  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         event_kind;
    logic [2:0]         channel;
    logic signed [15:0] value;
    logic               last;

    // frame predictor state, a shadow of the parser
    phase_t             pr_phase;
    logic [7:0]         pr_len;
    logic [7:0]         pr_cmd;
    logic [7:0]         pr_left;
    logic [7:0]         pr_payload [PayloadBytes];
    logic               pr_key;
    logic [OffsetW-1:0] pr_offset;

    rc_event_t  pending_events [$];   // expected results, oldest first
    rc_event_t  fresh_events [$];     // results of the byte just parsed
    rc_event_t  oldest;
    frame_row_t directed_rows [25];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int bytes_fed      = 0;
    bit calm           = 1'b0;        // no idling on either side while set

    remote_command_frame_parser_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .channel    (channel),
        .value      (value),
        .last       (last)
    );

    always #5 clk = ~clk;

    // advance the frame predictor by one received byte; results go to fresh_events
    task automatic parse_byte(input logic [7:0] b);
        logic [7:0]  pos;
        logic [16:0] target;
        logic [15:0] letter;
        rc_event_t   ev;
        letter = '0;
        case (pr_phase)
            PH_HUNT:
                if (b == SyncByte1)
                    pr_phase = PH_SYNC2;
            PH_SYNC2:
                // a repeated first header byte keeps us waiting for the second
                if (b == SyncByte2)
                    pr_phase = PH_LEN;
                else if (b != SyncByte1)
                    pr_phase = PH_HUNT;
            PH_LEN:
            begin
                pr_len   = b;
                pr_phase = (b < MinLen || b > MaxLen) ? PH_HUNT : PH_CMD;
            end
            PH_CMD:
            begin
                // store is cleared so a short frame reads zeros
                pr_cmd = b;
                foreach (pr_payload[k])
                    pr_payload[k] = 8'd0;
                pr_left  = pr_len - 8'd2;
                pr_phase = PH_BODY;
            end
            PH_BODY:
            begin
                if (pr_left <= 8'd1)
                begin
                    pr_left  = 8'd0;
                    pr_phase = PH_HUNT;
                    if (b == TrailerByte)
                    begin
                        case (pr_cmd)
                            CmdJoy:
                                for (int i = 0; i < JoyAxes; i++)
                                begin
                                    ev = '{KindJoy, 3'(i),
                                           {pr_payload[2*i], pr_payload[2*i+1]},
                                           i == JoyAxes - 1};
                                    fresh_events.push_back(ev);
                                end
                            CmdServo3, CmdServo4, CmdServo5:
                            begin
                                target = pr_offset + pr_payload[0];
                                if (target > ServoMax)
                                    target = ServoMax;
                                ev = '{KindServo, ChanServo3 + 3'(pr_cmd - CmdServo3),
                                       target[15:0], 1'b1};
                                fresh_events.push_back(ev);
                            end
                            CmdModeA: letter = LetterA;
                            CmdModeB: letter = LetterB;
                            CmdModeC: letter = LetterC;
                            CmdModeF: letter = LetterF;
                            CmdModeR: letter = LetterR;
                            CmdModeL: letter = LetterL;
                            CmdKey:
                            begin
                                pr_key = ~pr_key;
                                ev = '{KindKey, ChanNone, {15'd0, pr_key}, 1'b1};
                                fresh_events.push_back(ev);
                            end
                            default: ;
                        endcase
                        if (letter != '0)
                        begin
                            ev = '{KindMode, ChanNone, letter, 1'b1};
                            fresh_events.push_back(ev);
                        end
                    end
                end
                else
                begin
                    // bytes past the store are counted, not kept
                    pos = pr_len - 8'd2 - pr_left;
                    if (pos < PayloadBytes)
                        pr_payload[pos] = b;
                    pr_left = pr_left - 8'd1;
                end
            end
            default:
                pr_phase = PH_HUNT;
        endcase
    endtask

    // hand one byte to the block and predict what it causes
    task automatic feed_byte(input logic [7:0] b, input bit keep);
        if (!calm && $urandom_range(99) < IdlePct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IdlePct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_fed++;
        parse_byte(b);
        if (keep)
            foreach (fresh_events[k])
                pending_events.push_back(fresh_events[k]);
        fresh_events.delete();
    endtask

    task automatic send_frame(input frame_row_t row);
        bit keep;
        keep = (row.check == CHECK_MODEL);
        for (int i = row.nlead; i > 0; i--)
            feed_byte(row.lead[8*(i-1) +: 8], keep);
        feed_byte(SyncByte1, keep);
        feed_byte(SyncByte2, keep);
        feed_byte(row.len, keep);
        // a bad length ends the frame right there
        if (row.len >= MinLen && row.len <= MaxLen)
        begin
            feed_byte(row.cmd, keep);
            for (int i = 0; i < int'(row.len) - 3; i++)
                feed_byte(row.rnd_body ? 8'($urandom_range(255))
                                       : (i == 0 ? row.data0 : row.fill), keep);
            feed_byte(row.trailer, keep);
        end
        if (row.check == CHECK_ONE)
            pending_events.push_back(row.want);
    endtask

    // mostly known commands, now and then any byte
    function automatic logic [7:0] pick_command();
        case ($urandom_range(11))
            0:       return CmdJoy;
            1:       return CmdServo3;
            2:       return CmdServo4;
            3:       return CmdServo5;
            4:       return CmdModeA;
            5:       return CmdModeB;
            6:       return CmdModeC;
            7:       return CmdModeF;
            8:       return CmdKey;
            9:       return CmdModeR;
            10:      return CmdModeL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // a well-formed frame with random content, sometimes damaged
    task automatic send_random_frame();
        frame_row_t row;
        int         pick;
        row          = '0;
        row.check    = CHECK_MODEL;
        row.rnd_body = 1'b1;
        row.cmd      = pick_command();
        row.trailer  = TrailerByte;
        if (row.cmd == CmdJoy && $urandom_range(3) != 0)
            row.len = 8'd15;
        else if ($urandom_range(4) == 0)
            row.len = 8'($urandom_range(MaxLen, MinLen));
        else
            row.len = 8'($urandom_range(5, MinLen));
        pick = $urandom_range(99);
        if (pick < 10)
            row.trailer = 8'($urandom_range(255));
        else if (pick < 17)
            row.len = $urandom_range(1) ? 8'($urandom_range(2))
                                        : 8'($urandom_range(255, MaxLen + 1));
        else if (pick < 25)
        begin
            // loose bytes ahead of the header, often a stray first header byte
            row.nlead = 2'($urandom_range(2, 1));
            row.lead  = {$urandom_range(1) ? SyncByte1 : 8'($urandom_range(255)),
                         $urandom_range(1) ? SyncByte1 : 8'($urandom_range(255))};
        end
        send_frame(row);
    endtask

    // wait until every expected result is out, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SettleCycles)
            @(posedge clk);
    endtask

    task automatic write_offset(input logic [OffsetW-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pr_offset = v;
    endtask

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < IdlePct);

    // every result item is held against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: result with none expected: kind %0d chan %0d value %0d last %0d",
                         $time, event_kind, channel, value, last);
                mismatch_count++;
            end
            else
            begin
                oldest = pending_events.pop_front();
                if (event_kind !== oldest.kind)
                begin
                    $display("%0t: event_kind expected %0d actual %0d",
                             $time, oldest.kind, event_kind);
                    mismatch_count++;
                end
                if (channel !== oldest.chan)
                begin
                    $display("%0t: channel expected %0d actual %0d",
                             $time, oldest.chan, channel);
                    mismatch_count++;
                end
                if (value !== oldest.val)
                begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, $signed(oldest.val), value);
                    mismatch_count++;
                end
                if (last !== oldest.last)
                begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, oldest.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any item moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int         target_bytes;
        int         pick;
        logic [7:0] cut_len;

        // predictor starts from the reset state of the block
        pr_phase  = PH_HUNT;
        pr_len    = 8'd0;
        pr_cmd    = 8'd0;
        pr_left   = 8'd0;
        pr_key    = 1'b0;
        pr_offset = 15'd200;
        foreach (pr_payload[k])
            pr_payload[k] = 8'd0;

        // directed frames, servo rows rely on the reset offset of 200
        directed_rows = '{
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd4, CmdServo3, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindServo, ChanServo3, 16'd200, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd4, CmdServo4, 8'hFF, 8'h00, TrailerByte, 1'b0,
              '{KindServo, ChanServo4, 16'd455, 1'b1}},
            // no data byte at all: servo byte reads zero
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdServo5, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindServo, ChanServo5, 16'd200, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdModeA, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterA, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdModeB, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterB, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdModeC, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterC, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdModeF, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterF, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdModeR, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterR, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdModeL, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterL, 1'b1}},
            // key flag toggles on, then off
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdKey, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindKey, ChanNone, 16'd1, 1'b1}},
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd3, CmdKey, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindKey, ChanNone, 16'd0, 1'b1}},
            // joystick extremes: most negative axis, then most positive and minus one
            '{CHECK_MODEL, 2'd0, 16'h0000, 8'd15, CmdJoy, 8'h80, 8'h00, TrailerByte, 1'b0,
              NoEvent},
            '{CHECK_MODEL, 2'd0, 16'h0000, 8'd15, CmdJoy, 8'h7F, 8'hFF, TrailerByte, 1'b0,
              NoEvent},
            // short joystick frame, missing axes read zero
            '{CHECK_MODEL, 2'd0, 16'h0000, 8'd5, CmdJoy, 8'h12, 8'h34, TrailerByte, 1'b0,
              NoEvent},
            // longest legal frame, body full of header bytes
            '{CHECK_MODEL, 2'd0, 16'h0000, MaxLen, CmdJoy, SyncByte1, SyncByte2,
              TrailerByte, 1'b0, NoEvent},
            // doubled first header byte
            '{CHECK_ONE, 2'd1, 16'h00A5, 8'd3, CmdModeR, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterR, 1'b1}},
            // first header byte followed by junk, hunt restarts
            '{CHECK_ONE, 2'd2, 16'hA513, 8'd3, CmdModeL, 8'h00, 8'h00, TrailerByte, 1'b0,
              '{KindMode, ChanNone, LetterL, 1'b1}},
            // lengths just outside and far outside the legal range
            '{CHECK_NONE, 2'd0, 16'h0000, 8'd2, CmdModeA, 8'h00, 8'h00, TrailerByte, 1'b0,
              NoEvent},
            '{CHECK_NONE, 2'd0, 16'h0000, MaxLen + 8'd1, CmdModeA, 8'h00, 8'h00,
              TrailerByte, 1'b0, NoEvent},
            '{CHECK_NONE, 2'd0, 16'h0000, 8'hFF, CmdModeA, 8'h00, 8'h00, TrailerByte, 1'b0,
              NoEvent},
            '{CHECK_NONE, 2'd0, 16'h0000, 8'h00, CmdModeA, 8'h00, 8'h00, TrailerByte, 1'b0,
              NoEvent},
            // wrong trailer drops the frame
            '{CHECK_NONE, 2'd0, 16'h0000, 8'd3, CmdModeA, 8'h00, 8'h00, 8'h55, 1'b0,
              NoEvent},
            // unknown commands give nothing
            '{CHECK_NONE, 2'd0, 16'h0000, 8'd3, 8'h00, 8'h00, 8'h00, TrailerByte, 1'b0,
              NoEvent},
            '{CHECK_NONE, 2'd0, 16'h0000, 8'd4, 8'hFF, 8'h80, 8'h00, TrailerByte, 1'b0,
              NoEvent},
            // key frame carrying a data byte still just toggles
            '{CHECK_ONE, 2'd0, 16'h0000, 8'd4, CmdKey, 8'hFF, 8'h00, TrailerByte, 1'b0,
              '{KindKey, ChanNone, 16'd1, 1'b1}}
        };

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_frame(directed_rows[r]);

        // random phases, each under its own servo offset
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       write_offset('0);
                1:       write_offset('1);
                2:       write_offset(15'h7F01);    // saturation edge for the top bytes
                default: write_offset(15'($urandom_range(32767)));
            endcase
            calm         = (p == 2);
            target_bytes = bytes_fed + PhaseBytes;
            while (bytes_fed < target_bytes)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    send_random_frame();
                else if (pick < 90)
                begin
                    // line noise, rich in first header bytes
                    repeat ($urandom_range(4, 1))
                        feed_byte(($urandom_range(3) == 0) ? SyncByte1
                                                           : 8'($urandom_range(255)), 1'b1);
                end
                else
                begin
                    // frame cut short: what follows is swallowed as its body
                    cut_len = 8'($urandom_range(MaxLen, MinLen));
                    feed_byte(SyncByte1, 1'b1);
                    feed_byte(SyncByte2, 1'b1);
                    feed_byte(cut_len, 1'b1);
                    feed_byte(pick_command(), 1'b1);
                    repeat ($urandom_range(int'(cut_len) - 3))
                        feed_byte(8'($urandom_range(255)), 1'b1);
                end
            end
        end
        calm = 1'b0;

        drain_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
